/* hdl/mie_pkg.sv */
`default_nettype none
package mie_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam int STEP_W = 4;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             found;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DINIT_A,
    OP_DINIT_E,
    OP_DSTEP,
    OP_SET_R1,
    OP_UPDATE,
    OP_REDUCE,
    OP_SIGN,
    OP_FAIL,
    OP_PRESENT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_M_ZERO,
    C_DIV_MORE,
    C_R1_ZERO,
    C_R0_NOT_ONE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHK_M   = 4'd1;
  localparam logic [STEP_W-1:0] ST_DINIT_A = 4'd2;
  localparam logic [STEP_W-1:0] ST_DSTEP_A = 4'd3;
  localparam logic [STEP_W-1:0] ST_SET_R1  = 4'd4;
  localparam logic [STEP_W-1:0] ST_TOP     = 4'd5;
  localparam logic [STEP_W-1:0] ST_DINIT_E = 4'd6;
  localparam logic [STEP_W-1:0] ST_DSTEP_E = 4'd7;
  localparam logic [STEP_W-1:0] ST_UPDATE  = 4'd8;
  localparam logic [STEP_W-1:0] ST_CHK_1   = 4'd9;
  localparam logic [STEP_W-1:0] ST_REDUCE  = 4'd10;
  localparam logic [STEP_W-1:0] ST_SIGN    = 4'd11;
  localparam logic [STEP_W-1:0] ST_FAIL    = 4'd12;
  localparam logic [STEP_W-1:0] ST_OUT     = 4'd13;
  localparam logic [STEP_W-1:0] ST_BACK    = 4'd14;

  function automatic ctrl_t rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_WAIT};
    case (step)
      ST_WAIT:    w = '{op: OP_LOAD,    cond: C_NO_REQ,     target: ST_WAIT};
      ST_CHK_M:   w = '{op: OP_NOP,     cond: C_M_ZERO,     target: ST_FAIL};
      ST_DINIT_A: w = '{op: OP_DINIT_A, cond: C_NEVER,      target: ST_WAIT};
      ST_DSTEP_A: w = '{op: OP_DSTEP,   cond: C_DIV_MORE,   target: ST_DSTEP_A};
      ST_SET_R1:  w = '{op: OP_SET_R1,  cond: C_NEVER,      target: ST_WAIT};
      ST_TOP:     w = '{op: OP_NOP,     cond: C_R1_ZERO,    target: ST_CHK_1};
      ST_DINIT_E: w = '{op: OP_DINIT_E, cond: C_NEVER,      target: ST_WAIT};
      ST_DSTEP_E: w = '{op: OP_DSTEP,   cond: C_DIV_MORE,   target: ST_DSTEP_E};
      ST_UPDATE:  w = '{op: OP_UPDATE,  cond: C_ALWAYS,     target: ST_TOP};
      ST_CHK_1:   w = '{op: OP_NOP,     cond: C_R0_NOT_ONE, target: ST_FAIL};
      ST_REDUCE:  w = '{op: OP_REDUCE,  cond: C_NEVER,      target: ST_WAIT};
      ST_SIGN:    w = '{op: OP_SIGN,    cond: C_ALWAYS,     target: ST_OUT};
      ST_FAIL:    w = '{op: OP_FAIL,    cond: C_NEVER,      target: ST_WAIT};
      ST_OUT:     w = '{op: OP_PRESENT, cond: C_OUT_BUSY,   target: ST_OUT};
      ST_BACK:    w = '{op: OP_NOP,     cond: C_ALWAYS,     target: ST_WAIT};
      default:    w = '{op: OP_NOP,     cond: C_ALWAYS,     target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* hdl/mie_divider.sv */
`default_nettype none
module mie_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mie_pkg::div_ctrl_t         ctrl,
  input  wire logic [mie_pkg::WIDTH-1:0]  dividend,
  input  wire logic [mie_pkg::WIDTH-1:0]  divisor,
  input  wire logic [mie_pkg::WIDTH-1:0]  mac_in,
  output logic      [mie_pkg::WIDTH-1:0]  rem,
  output logic      [mie_pkg::WIDTH-1:0]  acc,
  output logic                            more
);
  import mie_pkg::*;

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] div_r, div_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             qbit;

  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    diff    = shifted - {1'b0, div_r};
    qbit    = ~diff[WIDTH];
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (ctrl.start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
      acc_nxt = '0;
      cnt_nxt = CNT_W'(WIDTH);
    end else if (ctrl.step) begin
      rem_nxt = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (qbit ? mac_in : '0);
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    acc_r <= acc_nxt;
  end

  assign rem  = rem_r;
  assign acc  = acc_r;
  assign more = (cnt_r != CNT_W'(1));

endmodule
`default_nettype wire

/* hdl/modular_inverse_extended_euclid.sv */
`default_nettype none
// channel   direction   payload                 handshake
// in        input       value, modulus (in_t)   in_valid / in_stall
// out       output      inverse, found (out_t)  out_valid / out_stall
//
// one request at a time; a division is driven by a microcoded sequencer
// synchronous active-low reset clears the step counter and output valid
// in_stall is low only in the wait step; a result waits in the output register
// while the next request is taken
module modular_inverse_extended_euclid (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mie_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mie_pkg::out_t       out_data
);
  import mie_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ctrl_t             cw;
  logic              jump;
  logic              accept;

  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] r0_r, r0_nxt;
  logic [WIDTH-1:0] r1_r, r1_nxt;
  logic [WIDTH-1:0] mag0_r, mag0_nxt;
  logic [WIDTH-1:0] mag1_r, mag1_nxt;
  logic             neg0_r, neg0_nxt;
  logic             neg1_r, neg1_nxt;
  logic [WIDTH-1:0] red_r, red_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_busy;

  div_ctrl_t        dctrl;
  logic [WIDTH-1:0] d_dividend;
  logic [WIDTH-1:0] d_divisor;
  logic [WIDTH-1:0] d_rem;
  logic [WIDTH-1:0] d_acc;
  logic             d_more;

  assign cw       = rom(pc_r);
  assign in_stall = (pc_r != ST_WAIT);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;

  assign dctrl.start = (cw.op == OP_DINIT_A) || (cw.op == OP_DINIT_E);
  assign dctrl.step  = (cw.op == OP_DSTEP);
  assign d_dividend  = (cw.op == OP_DINIT_A) ? a_r : r0_r;
  assign d_divisor   = (cw.op == OP_DINIT_A) ? m_r : r1_r;

  mie_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (dctrl),
    .dividend (d_dividend),
    .divisor  (d_divisor),
    .mac_in   (mag1_r),
    .rem      (d_rem),
    .acc      (d_acc),
    .more     (d_more)
  );

  always_comb begin
    case (cw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_REQ:     jump = !in_valid;
      C_M_ZERO:     jump = (m_r == '0);
      C_DIV_MORE:   jump = d_more;
      C_R1_ZERO:    jump = (r1_r == '0);
      C_R0_NOT_ONE: jump = (r0_r != WIDTH'(1));
      C_OUT_BUSY:   jump = out_busy;
      default:      jump = 1'b0;
    endcase
    pc_nxt = jump ? cw.target : pc_r + 1'b1;
  end

  always_comb begin
    a_nxt         = a_r;
    m_nxt         = m_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    mag0_nxt      = mag0_r;
    mag1_nxt      = mag1_r;
    neg0_nxt      = neg0_r;
    neg1_nxt      = neg1_r;
    red_nxt       = red_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (cw.op)
      OP_LOAD: begin
        if (accept) begin
          a_nxt    = in_data.value;
          m_nxt    = in_data.modulus;
          r0_nxt   = in_data.modulus;
          mag0_nxt = '0;
          mag1_nxt = WIDTH'(1);
          neg0_nxt = 1'b0;
          neg1_nxt = 1'b0;
        end
      end
      OP_SET_R1: begin
        r1_nxt = d_rem;
      end
      OP_UPDATE: begin
        r0_nxt   = r1_r;
        r1_nxt   = d_rem;
        mag0_nxt = mag1_r;
        mag1_nxt = mag0_r + d_acc;
        neg0_nxt = neg1_r;
        neg1_nxt = !neg1_r;
      end
      OP_REDUCE: begin
        red_nxt = (mag0_r >= m_r) ? mag0_r - m_r : mag0_r;
      end
      OP_SIGN: begin
        res_nxt.inverse = (neg0_r && red_r != '0) ? m_r - red_r : red_r;
        res_nxt.found   = 1'b1;
      end
      OP_FAIL: begin
        res_nxt.inverse = '0;
        res_nxt.found   = 1'b0;
      end
      OP_PRESENT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result staging: res_r feeds the output register only when presented
  out_t out_r, out_nxt;

  always_comb begin
    out_nxt = out_r;
    if (cw.op == OP_PRESENT && !out_busy) begin
      out_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r    <= a_nxt;
    m_r    <= m_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    mag0_r <= mag0_nxt;
    mag1_r <= mag1_nxt;
    neg0_r <= neg0_nxt;
    neg1_r <= neg1_nxt;
    red_r  <= red_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mie_pkg::*;

  localparam int DIRECTED_COUNT = 22;
  localparam int RANDOM_COUNT = 350;
  localparam int QUIET_TAIL = 40;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
    bit               given;
    logic [WIDTH-1:0] inverse;
    bit               found;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit   idle_on = 1'b1;
  int   stall_left = 0;
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   no_inverse_seen = 0;
  int   requests_sent = 0;
  out_t expected_inverses[$];
  logic [WIDTH-1:0] fib [48];
  directed_row_t directed_rows [DIRECTED_COUNT];

  modular_inverse_extended_euclid dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // extended euclid with the coefficient held as magnitude and sign
  function automatic out_t modular_inverse(input in_t req);
    logic [2*WIDTH-1:0] r0, r1, r2, quot, mag0, mag1, mag2, red, m;
    bit neg0, neg1, neg2;
    out_t res;
    res = '0;
    m = {{WIDTH{1'b0}}, req.modulus};
    if (m == 0) return res;
    r0 = m;
    r1 = {{WIDTH{1'b0}}, req.value} % m;
    mag0 = 0;
    neg0 = 1'b0;
    mag1 = 1;
    neg1 = 1'b0;
    while (r1 != 0) begin
      quot = r0 / r1;
      r2 = r0 - quot * r1;
      mag2 = mag0 + quot * mag1;
      neg2 = !neg1;
      r0 = r1;
      r1 = r2;
      mag0 = mag1;
      neg0 = neg1;
      mag1 = mag2;
      neg1 = neg2;
    end
    if (r0 != 1) return res;
    red = mag0 % m;
    if (neg0 && red != 0) red = m - red;
    res.inverse = red[WIDTH-1:0];
    res.found = 1'b1;
    return res;
  endfunction

  task automatic offer(input in_t req, input out_t exp);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    expected_inverses.insert(expected_inverses.size(), exp);
    requests_sent++;
  endtask

  task automatic make_request(output in_t req);
    int kind;
    int k;
    logic [WIDTH-1:0] g;
    kind = $urandom_range(0, 9);
    req.value = $urandom;
    req.modulus = $urandom;
    case (kind)
      4: req.modulus = $urandom_range(1, 64);
      5: begin
        g = $urandom_range(2, 255);
        req.value = g * $urandom_range(0, 24'hFF_FFFF);
        req.modulus = g * $urandom_range(1, 24'hFF_FFFF);
      end
      6: begin
        if ($urandom_range(0, 1) == 0) req.modulus = $urandom_range(1, 2);
        else req.value = '0;
      end
      7: begin
        k = $urandom_range(1, 46);
        if ($urandom_range(0, 1) == 0) begin
          req.value = fib[k];
          req.modulus = fib[k+1];
        end else begin
          req.value = fib[k+1];
          req.modulus = fib[k];
        end
      end
      8: req.value = req.modulus + $urandom_range(0, 3) - 1;
      9: begin
        req.value[WIDTH-1] = 1'b1;
        req.modulus[WIDTH-1] = 1'b1;
      end
      default: ;
    endcase
    if (req.modulus == 0) req.modulus = 1;
  endtask

  // receiver: random stall bursts, and the result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (!out_data.found) no_inverse_seen++;
      if (expected_inverses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("tb: result with no request pending: inverse %h found %b",
                   out_data.inverse, out_data.found);
      end else begin
        if (out_data.inverse !== expected_inverses[0].inverse) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: inverse mismatch: expected %h actual %h",
                     expected_inverses[0].inverse, out_data.inverse);
        end
        if (out_data.found !== expected_inverses[0].found) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: found mismatch: expected %b actual %b",
                     expected_inverses[0].found, out_data.found);
        end
        void'(expected_inverses.pop_front());
      end
    end
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_t  req;
    out_t exp;
    fib[0] = '0;
    fib[1] = 1;
    for (int i = 2; i < 48; i++) fib[i] = fib[i-1] + fib[i-2];
    directed_rows = '{
      '{32'd0,          32'd1,          1'b1, 32'd0,          1'b1},
      '{32'hFFFF_FFFF,  32'd1,          1'b1, 32'd0,          1'b1},
      '{32'd0,          32'd2,          1'b1, 32'd0,          1'b0},
      '{32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0,          1'b0},
      '{32'd5,          32'd0,          1'b1, 32'd0,          1'b0},
      '{32'd0,          32'd0,          1'b1, 32'd0,          1'b0},
      '{32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0,          1'b0},
      '{32'd1,          32'd2,          1'b1, 32'd1,          1'b1},
      '{32'd1,          32'hFFFF_FFFF,  1'b1, 32'd1,          1'b1},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0,          1'b0},
      '{32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFE,  1'b1},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'd1,          1'b1},
      '{32'd6,          32'd9,          1'b1, 32'd0,          1'b0},
      '{32'd2,          32'h8000_0000,  1'b1, 32'd0,          1'b0},
      '{32'd3,          32'd7,          1'b0, 32'd0,          1'b0},
      '{32'd1836311903, 32'd2971215073, 1'b0, 32'd0,          1'b0},
      '{32'd2971215073, 32'd1836311903, 1'b0, 32'd0,          1'b0},
      '{32'h8000_0000,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},
      '{32'd12345,      32'd4294967291, 1'b0, 32'd0,          1'b0},
      '{32'hDEAD_BEEF,  32'h0001_0001,  1'b0, 32'd0,          1'b0},
      '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'd0,          1'b0},
      '{32'h5555_5555,  32'hAAAA_AAAB,  1'b0, 32'd0,          1'b0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      req.value = directed_rows[i].value;
      req.modulus = directed_rows[i].modulus;
      if (directed_rows[i].given) begin
        exp.inverse = directed_rows[i].inverse;
        exp.found = directed_rows[i].found;
      end else begin
        exp = modular_inverse(req);
      end
      offer(req, exp);
    end

    for (int r = 0; r < RANDOM_COUNT; r++) begin
      idle_on <= ((r / 50) % 4 != 3) && (r < RANDOM_COUNT - QUIET_TAIL);
      make_request(req);
      offer(req, modular_inverse(req));
      // hold off until the block has handed back everything
      if (r == RANDOM_COUNT / 2) begin
        in_valid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests sent (%0d directed, %0d random)",
             requests_sent, DIRECTED_COUNT, RANDOM_COUNT);
    $display("tb: %0d results checked, %0d without an inverse, %0d mismatches",
             results_seen, no_inverse_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
